/* hdl/psh_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PC stall histogram profiler package
// Shared sizes, request codes, command format and status groups.
// ----------------------------------------------------------------------------
package psh_pkg;

    localparam int NUM_PROCS     = 16;
    localparam int PC_BINS       = 1024;
    localparam int COUNT_W       = 32;
    localparam int STALL_BIT_POS = 31;
    localparam int PC_LSB        = 0;

    localparam int PROC_W = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
    localparam int PC_W   = (PC_BINS > 1) ? $clog2(PC_BINS) : 1;
    localparam int ADDR_W = PROC_W + PC_W;

    localparam int REQ_W     = 2;
    localparam int IDX_W     = 4;
    localparam int STAT_W    = 32;
    localparam int BIN_W     = 10;
    localparam int MASK_W    = 16;
    localparam int OUT_W     = 32;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 96;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [REQ_W-1:0] REQ_RECORD = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;

    typedef enum logic [2:0] {
        OP_INC_DIS = 3'd0,
        OP_INC_RUN = 3'd1,
        OP_INC_BIN = 3'd2,
        OP_CLEAR   = 3'd3,
        OP_READ    = 3'd4,
        OP_NODATA  = 3'd5
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [PROC_W-1:0] proc;
        logic [PC_W-1:0]   bin;
        logic              bin_ok;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic not_empty;
    } t_q_stat;

    typedef struct packed {
        logic init_busy;
    } t_back_stat;

endpackage
`default_nettype wire

/* hdl/psh_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Command queue
// Short FIFO of classified commands between the front and back parts.
// ----------------------------------------------------------------------------
module psh_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  psh_pkg::t_cmd        i_cmd,
    input  wire logic            i_pop,
    output psh_pkg::t_cmd        o_cmd,
    output psh_pkg::t_q_stat     o_stat
);

    psh_pkg::t_cmd                   r_ent [psh_pkg::QUEUE_DEPTH];
    logic [psh_pkg::QPTR_W-1:0]      r_wr_ptr, n_wr_ptr;
    logic [psh_pkg::QPTR_W-1:0]      r_rd_ptr, n_rd_ptr;
    logic [psh_pkg::QCNT_W-1:0]      r_cnt, n_cnt;

    function automatic logic [psh_pkg::QPTR_W-1:0] ptr_inc(
        input logic [psh_pkg::QPTR_W-1:0] ptr
    );
        if (32'(ptr) == psh_pkg::QUEUE_DEPTH - 1) begin
            return '0;
        end
        return ptr + 1'b1;
    endfunction

    always_comb begin
        n_wr_ptr = i_push ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_cnt    = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_cmd            = r_ent[r_rd_ptr];
    assign o_stat.full      = (32'(r_cnt) == psh_pkg::QUEUE_DEPTH);
    assign o_stat.not_empty = (r_cnt != '0);

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && !i_pop && o_stat.full))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_stat.not_empty)
        else $error("queue pop while empty");

endmodule
`default_nettype wire

/* hdl/psh_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Request front end
// Holds the sample mask and store-present flags, accepts requests and turns
// them into commands for the back end.
// ----------------------------------------------------------------------------
module psh_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [psh_pkg::MASK_W-1:0]    i_cfg_data,
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    input  wire logic [psh_pkg::S_TDATA_W-1:0] i_s_tdata,
    input  wire logic [psh_pkg::REQ_W-1:0]     i_s_tuser,
    input  psh_pkg::t_q_stat                   i_q_stat,
    input  psh_pkg::t_back_stat                i_back_stat,
    output logic                               o_push,
    output psh_pkg::t_cmd                      o_cmd
);

    logic [psh_pkg::MASK_W-1:0]    r_mask, n_mask;
    logic [psh_pkg::NUM_PROCS-1:0] r_pres, n_pres;

    logic [psh_pkg::IDX_W-1:0]  proc_index;
    logic                       proc_enabled;
    logic [psh_pkg::STAT_W-1:0] status_word;
    logic [psh_pkg::BIN_W-1:0]  bin_index;
    logic [psh_pkg::STAT_W-1:0] pc_shifted;
    logic [psh_pkg::PC_W-1:0]   pc;
    logic [psh_pkg::PROC_W-1:0] proc;
    logic                       proc_ok;
    logic                       present;
    logic                       pc_ok;
    logic                       want;
    logic                       accept;

    assign proc_index   = i_s_tdata[3:0];
    assign proc_enabled = i_s_tdata[4];
    assign status_word  = i_s_tdata[36:5];
    assign bin_index    = i_s_tdata[46:37];

    assign proc       = psh_pkg::PROC_W'(proc_index);
    assign proc_ok    = (32'(proc_index) < psh_pkg::NUM_PROCS);
    assign present    = proc_ok && r_pres[proc];
    assign pc_shifted = status_word >> psh_pkg::PC_LSB;
    assign pc         = psh_pkg::PC_W'(pc_shifted);
    assign pc_ok      = (32'(pc) < psh_pkg::PC_BINS);

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !i_q_stat.full && !i_back_stat.init_busy;
    assign accept      = i_s_tvalid && o_s_tready;
    assign o_push      = accept && want;

    always_comb begin
        want         = 1'b0;
        o_cmd.op     = psh_pkg::OP_INC_DIS;
        o_cmd.proc   = proc;
        o_cmd.bin    = psh_pkg::PC_W'(bin_index);
        o_cmd.bin_ok = (32'(bin_index) < psh_pkg::PC_BINS);
        case (i_s_tuser)
            psh_pkg::REQ_RECORD: begin
                if (proc_ok && r_mask[proc_index]) begin
                    if (!proc_enabled) begin
                        want     = 1'b1;
                        o_cmd.op = psh_pkg::OP_INC_DIS;
                    end else if (status_word[psh_pkg::STALL_BIT_POS]) begin
                        want      = pc_ok;
                        o_cmd.op  = psh_pkg::OP_INC_BIN;
                        o_cmd.bin = pc;
                    end else begin
                        want     = 1'b1;
                        o_cmd.op = psh_pkg::OP_INC_RUN;
                    end
                end
            end
            psh_pkg::REQ_CLEAR: begin
                want     = present;
                o_cmd.op = psh_pkg::OP_CLEAR;
            end
            psh_pkg::REQ_READ: begin
                want     = 1'b1;
                o_cmd.op = present ? psh_pkg::OP_READ : psh_pkg::OP_NODATA;
            end
            default: begin
                want = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_mask = r_mask;
        n_pres = r_pres;
        if (i_cfg_valid && o_cfg_ready) begin
            n_mask = i_cfg_data;
            n_pres = r_pres | psh_pkg::NUM_PROCS'(i_cfg_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
            r_pres <= '0;
        end else begin
            r_mask <= n_mask;
            r_pres <= n_pres;
        end
    end

endmodule
`default_nettype wire

/* hdl/psh_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Histogram back end
// Executes queued commands against the counters and the stall bin memory
// and drives the registered result word.
// ----------------------------------------------------------------------------
module psh_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  psh_pkg::t_cmd                      i_cmd,
    input  psh_pkg::t_q_stat                   i_q_stat,
    output logic                               o_pop,
    output psh_pkg::t_back_stat                o_stat,
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    output logic [psh_pkg::M_TDATA_W-1:0]      o_m_tdata,
    output logic                               o_m_tuser
);

    typedef enum logic [4:0] {
        S_INIT   = 5'b00001,
        S_IDLE   = 5'b00010,
        S_BIN_WR = 5'b00100,
        S_READ   = 5'b01000,
        S_CLEAR  = 5'b10000
    } t_state;

    localparam int MEM_DEPTH = 2 ** psh_pkg::ADDR_W;

    t_state                          r_state, n_state;
    logic [psh_pkg::ADDR_W-1:0]      r_sweep, n_sweep;
    psh_pkg::t_cmd                   r_cur, n_cur;
    logic [psh_pkg::COUNT_W-1:0]     r_dis [psh_pkg::NUM_PROCS];
    logic [psh_pkg::COUNT_W-1:0]     r_run [psh_pkg::NUM_PROCS];
    logic [psh_pkg::COUNT_W-1:0]     r_dis_hold, r_run_hold;
    logic [psh_pkg::COUNT_W-1:0]     r_mem [MEM_DEPTH];
    logic [psh_pkg::COUNT_W-1:0]     r_rdata;
    logic                            r_out_valid, n_out_valid;
    logic                            r_out_status, n_out_status;
    logic [psh_pkg::OUT_W-1:0]       r_out_dis, n_out_dis;
    logic [psh_pkg::OUT_W-1:0]       r_out_run, n_out_run;
    logic [psh_pkg::OUT_W-1:0]       r_out_stall, n_out_stall;

    logic                            out_free;
    logic                            out_load;
    logic                            mem_we;
    logic [psh_pkg::ADDR_W-1:0]      mem_waddr;
    logic [psh_pkg::COUNT_W-1:0]     mem_wdata;
    logic                            mem_re;
    logic [psh_pkg::ADDR_W-1:0]      mem_raddr;
    logic                            dis_inc;
    logic                            run_inc;
    logic                            cnt_clr;
    logic                            hold_load;
    logic                            clear_last;

    assign out_free   = !r_out_valid || i_m_tready;
    assign mem_raddr  = {i_cmd.proc, i_cmd.bin};
    assign clear_last = (32'(r_sweep[psh_pkg::PC_W-1:0]) == psh_pkg::PC_BINS - 1);

    always_comb begin
        n_state      = r_state;
        n_sweep      = r_sweep;
        n_cur        = r_cur;
        o_pop        = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = r_sweep;
        mem_wdata    = '0;
        mem_re       = 1'b0;
        dis_inc      = 1'b0;
        run_inc      = 1'b0;
        cnt_clr      = 1'b0;
        hold_load    = 1'b0;
        out_load     = 1'b0;
        n_out_status = r_out_status;
        n_out_dis    = r_out_dis;
        n_out_run    = r_out_run;
        n_out_stall  = r_out_stall;
        case (r_state)
            S_INIT: begin
                mem_we  = 1'b1;
                n_sweep = r_sweep + 1'b1;
                if (r_sweep == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_q_stat.not_empty) begin
                    case (i_cmd.op)
                        psh_pkg::OP_INC_DIS: begin
                            o_pop   = 1'b1;
                            dis_inc = 1'b1;
                        end
                        psh_pkg::OP_INC_RUN: begin
                            o_pop   = 1'b1;
                            run_inc = 1'b1;
                        end
                        psh_pkg::OP_INC_BIN: begin
                            o_pop   = 1'b1;
                            mem_re  = 1'b1;
                            n_cur   = i_cmd;
                            n_state = S_BIN_WR;
                        end
                        psh_pkg::OP_CLEAR: begin
                            o_pop   = 1'b1;
                            cnt_clr = 1'b1;
                            n_cur   = i_cmd;
                            n_sweep = '0;
                            n_state = S_CLEAR;
                        end
                        psh_pkg::OP_READ: begin
                            if (out_free) begin
                                o_pop     = 1'b1;
                                mem_re    = 1'b1;
                                hold_load = 1'b1;
                                n_cur     = i_cmd;
                                n_state   = S_READ;
                            end
                        end
                        psh_pkg::OP_NODATA: begin
                            if (out_free) begin
                                o_pop        = 1'b1;
                                out_load     = 1'b1;
                                n_out_status = 1'b1;
                                n_out_dis    = '0;
                                n_out_run    = '0;
                                n_out_stall  = '0;
                            end
                        end
                        default: begin
                            o_pop = 1'b1;
                        end
                    endcase
                end
            end
            S_BIN_WR: begin
                mem_we    = 1'b1;
                mem_waddr = {r_cur.proc, r_cur.bin};
                mem_wdata = r_rdata + 1'b1;
                n_state   = S_IDLE;
            end
            S_READ: begin
                out_load     = 1'b1;
                n_out_status = 1'b0;
                n_out_dis    = psh_pkg::OUT_W'(r_dis_hold);
                n_out_run    = psh_pkg::OUT_W'(r_run_hold);
                n_out_stall  = r_cur.bin_ok ? psh_pkg::OUT_W'(r_rdata) : '0;
                n_state      = S_IDLE;
            end
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = {r_cur.proc, r_sweep[psh_pkg::PC_W-1:0]};
                n_sweep   = r_sweep + 1'b1;
                if (clear_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
                n_sweep = '0;
            end
        endcase
        n_out_valid = out_load ? 1'b1 : (i_m_tready ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_sweep     <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < psh_pkg::NUM_PROCS; i++) begin
                r_dis[i] <= '0;
                r_run[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_sweep     <= n_sweep;
            r_out_valid <= n_out_valid;
            if (dis_inc) begin
                r_dis[i_cmd.proc] <= r_dis[i_cmd.proc] + 1'b1;
            end
            if (run_inc) begin
                r_run[i_cmd.proc] <= r_run[i_cmd.proc] + 1'b1;
            end
            if (cnt_clr) begin
                r_dis[i_cmd.proc] <= '0;
                r_run[i_cmd.proc] <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur        <= n_cur;
        r_out_status <= n_out_status;
        r_out_dis    <= n_out_dis;
        r_out_run    <= n_out_run;
        r_out_stall  <= n_out_stall;
        if (hold_load) begin
            r_dis_hold <= r_dis[i_cmd.proc];
            r_run_hold <= r_run[i_cmd.proc];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    assign o_stat.init_busy = (r_state == S_INIT);
    assign o_m_tvalid       = r_out_valid;
    assign o_m_tdata        = {r_out_stall, r_out_run, r_out_dis};
    assign o_m_tuser        = r_out_status;

    a_no_pop_in_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INIT) |-> !o_pop)
        else $error("command taken during the reset sweep");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> out_free)
        else $error("result overwritten before it was taken");

    a_clear_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) && clear_last |=> (r_state == S_IDLE))
        else $error("clear sweep did not end after the last bin");

    a_read_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |=> o_m_tvalid)
        else $error("read finished without a result");

endmodule
`default_nettype wire

/* hdl/pc_stall_histogram_profiler_core.sv */
// Flow: a request enters the command queue on acceptance and is registered
// there; the back end takes it from the queue head in S_IDLE. Counter records
// finish in S_IDLE; stalled records pass through S_BIN_WR, reads through S_READ,
// and a clear sweeps the PC_BINS bins in S_CLEAR; these three share one memory.
// Reset: synchronous; afterward the 16384 memory entries are zeroed, one entry
// per cycle, while no request is accepted (configuration still is).
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PC stall histogram profiler core
// Per-processor sample profiler with counters and a stall histogram.
// ----------------------------------------------------------------------------
module pc_stall_histogram_profiler_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [psh_pkg::MASK_W-1:0]    i_cfg_data,
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    // proc_index, proc_enabled, status_word, bin_index, zero fill
    input  wire logic [psh_pkg::S_TDATA_W-1:0] i_s_tdata,
    // req_type
    input  wire logic [psh_pkg::REQ_W-1:0]     i_s_tuser,
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    // disabled_count, running_count, stall_count
    output logic [psh_pkg::M_TDATA_W-1:0]      o_m_tdata,
    // read_status
    output logic                               o_m_tuser
);

    psh_pkg::t_q_stat    q_stat;
    psh_pkg::t_back_stat back_stat;
    psh_pkg::t_cmd       push_cmd;
    psh_pkg::t_cmd       head_cmd;
    logic                push;
    logic                pop;

    psh_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_q_stat    (q_stat),
        .i_back_stat (back_stat),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    psh_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_stat  (q_stat)
    );

    psh_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (head_cmd),
        .i_q_stat   (q_stat),
        .o_pop      (pop),
        .o_stat     (back_stat),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule
`default_nettype wire
